// ===== hw/rtl/cas_pkg.sv =====
// Shared types, widths and codes for the compacting array store.
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

    // Field widths of the item and result beats.
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 10;
    localparam int COORD_W  = 10;
    localparam int DIM_W    = 11;
    localparam int COUNT_W  = 11;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Coordinate reads use up to four dimensions.
    localparam int MAX_DIMS = 4;
    localparam int DIX_W    = $clog2(MAX_DIMS);
    localparam int DIMCNT_W = 3;

    // A row-major flat index is below (outermost coordinate + 1) times the
    // product of the inner extents, so it fits here without wrapping.
    localparam int FLAT_W = COORD_W + (MAX_DIMS - 1) * DIM_W;

    // Configuration port.
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic [DIM_W-1:0]          dim_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [OP_W-1:0]           op_t;
    typedef logic [STATUS_W-1:0]       status_t;
    typedef logic [DIMCNT_W-1:0]       dimcnt_t;
    typedef logic [FLAT_W-1:0]         flat_t;
    typedef logic [PDATA_W-1:0]        pdata_t;
    typedef logic [REG_IDX_W-1:0]      reg_idx_t;

    typedef coord_t [MAX_DIMS-1:0] coord_vec_t;
    typedef dim_t   [MAX_DIMS-1:0] dim_vec_t;

    // Operation codes.
    localparam op_t OP_APPEND = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_READ   = 2'd2;
    localparam op_t OP_COORD  = 2'd3;

    // Status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_INDEX = 2'd1;
    localparam status_t ST_COORD = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Register indexes on the configuration port.
    localparam reg_idx_t REG_DIMS_IN_USE = 3'd0;
    localparam reg_idx_t REG_DIM_SIZE_0  = 3'd1;
    localparam reg_idx_t REG_DIM_SIZE_1  = 3'd2;
    localparam reg_idx_t REG_DIM_SIZE_2  = 3'd3;
    localparam reg_idx_t REG_DIM_SIZE_3  = 3'd4;

    // Answer of the coordinate flattening unit.
    typedef struct packed {
        logic  done;
        logic  coord_err;
        flat_t flat;
    } flat_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cas_in_if.sv =====
// Item channel of the compacting array store: valid, ready and the item fields.
`timescale 1ns / 1ps
`default_nettype none

interface cas_in_if;
    logic            valid;
    logic            ready;
    cas_pkg::op_t    operation;
    cas_pkg::value_t value;
    cas_pkg::idx_t   index;
    cas_pkg::coord_t coord_0;
    cas_pkg::coord_t coord_1;
    cas_pkg::coord_t coord_2;
    cas_pkg::coord_t coord_3;

    modport source (
        output valid, operation, value, index, coord_0, coord_1, coord_2, coord_3,
        input  ready
    );

    modport sink (
        input  valid, operation, value, index, coord_0, coord_1, coord_2, coord_3,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/cas_out_if.sv =====
// Result channel of the compacting array store: valid, ready and the result fields.
`timescale 1ns / 1ps
`default_nettype none

interface cas_out_if;
    logic               valid;
    logic               ready;
    cas_pkg::value_t    read_value;
    cas_pkg::status_t   status;
    cas_pkg::count_t    element_count;

    modport source (
        output valid, read_value, status, element_count,
        input  ready
    );

    modport sink (
        input  valid, read_value, status, element_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/cas_flatten.sv =====
// Coordinate check and iterative row-major flattening, one dimension per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cas_flatten (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire cas_pkg::coord_vec_t coords,
    input  wire cas_pkg::dim_vec_t   dims,
    input  wire cas_pkg::dimcnt_t    dims_used,
    output cas_pkg::flat_rsp_t       rsp
);

    logic                busy_reg, busy_next;
    logic                err_reg, err_next;
    cas_pkg::dimcnt_t    step_reg, step_next;
    cas_pkg::flat_t      flat_reg, flat_next;
    cas_pkg::coord_vec_t coords_reg, coords_next;

    logic                           start_err;
    logic                           done;
    logic [cas_pkg::DIX_W-1:0]      step_sel;
    logic [cas_pkg::FLAT_W+cas_pkg::DIM_W-1:0] prod;

    // Any used coordinate at or beyond its extent is rejected up front.
    always_comb
    begin
        start_err = 1'b0;
        for (int i = 0; i < cas_pkg::MAX_DIMS; i++)
        begin
            if ((cas_pkg::dimcnt_t'(i) < dims_used) &&
                (cas_pkg::dim_t'(coords[i]) >= dims[i]))
            begin
                start_err = 1'b1;
            end
        end
    end

    // One multiply-add per cycle: flat = flat * extent + coordinate.
    assign step_sel = step_reg[cas_pkg::DIX_W-1:0];
    assign prod     = flat_reg * dims[step_sel];
    assign done     = busy_reg && (err_reg || (step_reg == dims_used));

    always_comb
    begin
        busy_next   = busy_reg;
        err_next    = err_reg;
        step_next   = step_reg;
        flat_next   = flat_reg;
        coords_next = coords_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            err_next    = start_err;
            step_next   = '0;
            flat_next   = '0;
            coords_next = coords;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            flat_next = prod[cas_pkg::FLAT_W-1:0] + cas_pkg::flat_t'(coords_reg[step_sel]);
            step_next = step_reg + cas_pkg::dimcnt_t'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            err_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            err_reg  <= err_next;
            step_reg <= step_next;
        end
    end

    // Working values.
    always_ff @(posedge clk)
    begin
        flat_reg   <= flat_next;
        coords_reg <= coords_next;
    end

    assign rsp.done      = done;
    assign rsp.coord_err = err_reg;
    assign rsp.flat      = flat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/compacting_array_store_top.sv =====
// Top level of the compacting array store: control, element memory and register port.
`timescale 1ns / 1ps
`default_nettype none

// The store keeps up to DEPTH signed 32-bit elements packed in order in one
// synchronous memory with a registered read. One item is worked on at a time and
// every item gives one result beat carrying the element count after it. An
// append, and a read or remove whose index is at or beyond the count, finishes
// in the cycle it is accepted. A read addresses the memory in the idle state and
// takes the data in S_RD. A coordinate read is paced by the flattening unit's
// single multiplier, which handles one dimension per cycle; a coordinate out of
// its extent ends it as soon as that unit reports done, and a flat index at or
// beyond the count ends it without a memory read. A remove moves the elements
// above the index (the count less the index less one) down one place, the memory
// reading one entry and writing one entry each cycle. An item whose result finds
// the output register still held waits in a holding slot until that register
// frees. The user must write the dimension registers over the APB-style port
// only while idle; the block itself does not enforce it.
module compacting_array_store_top #(
    parameter int DEPTH = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cas_in_if.sink                           item,
    cas_out_if.source                        result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cas_pkg::PADDR_W-1:0] paddr,
    input  wire cas_pkg::pdata_t             pwdata,
    output cas_pkg::pdata_t                  prdata,
    output logic                             pready
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Control states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLAT  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    ptr_reg, ptr_next;

    cas_pkg::dimcnt_t dims_in_use_reg;
    cas_pkg::dim_vec_t dim_size_reg;

    cas_pkg::value_t  pend_value_reg, pend_value_next;
    cas_pkg::status_t pend_status_reg, pend_status_next;

    logic             out_valid_reg, out_valid_next;
    cas_pkg::value_t  out_value_reg, out_value_next;
    cas_pkg::status_t out_status_reg, out_status_next;
    cas_pkg::count_t  out_count_reg, out_count_next;

    // Element memory.
    cas_pkg::value_t  mem [DEPTH];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    cas_pkg::value_t  mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    cas_pkg::value_t  mem_rdata;

    // Result of the current item, when it finishes this cycle.
    logic             fin;
    cas_pkg::value_t  fin_value;
    cas_pkg::status_t fin_status;

    logic             out_free;
    logic             accept;
    logic             cfg_write;
    cas_pkg::reg_idx_t reg_idx;

    cas_pkg::flat_t   cnt_w;
    cas_pkg::flat_t   idx_w;
    cas_pkg::flat_t   idx_inc;
    cas_pkg::flat_t   ptr_inc;

    cas_pkg::dimcnt_t    dims_used;
    cas_pkg::coord_vec_t coords_in;
    logic                flat_start;
    cas_pkg::flat_rsp_t  flat_rsp;

    assign out_free = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign accept = item.valid && (state_reg == S_IDLE);

    // Index arithmetic is done at the flat width so nothing wraps.
    assign cnt_w   = cas_pkg::flat_t'(count_reg);
    assign idx_w   = cas_pkg::flat_t'(item.index);
    assign idx_inc = idx_w + cas_pkg::flat_t'(1);
    assign ptr_inc = cas_pkg::flat_t'(ptr_reg) + cas_pkg::flat_t'(1);

    // Coordinate flattening unit.
    assign dims_used = (dims_in_use_reg > cas_pkg::dimcnt_t'(cas_pkg::MAX_DIMS)) ?
                       cas_pkg::dimcnt_t'(cas_pkg::MAX_DIMS) : dims_in_use_reg;
    assign coords_in[0] = item.coord_0;
    assign coords_in[1] = item.coord_1;
    assign coords_in[2] = item.coord_2;
    assign coords_in[3] = item.coord_3;

    cas_flatten u_flatten (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (flat_start),
        .coords    (coords_in),
        .dims      (dim_size_reg),
        .dims_used (dims_used),
        .rsp       (flat_rsp)
    );

    // Sequencer: memory accesses, count update and the finishing result.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        flat_start = 1'b0;
        fin        = 1'b0;
        fin_value  = '0;
        fin_status = cas_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.operation)
                        cas_pkg::OP_APPEND:
                        begin
                            fin = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                fin_status = cas_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = item.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        cas_pkg::OP_REMOVE:
                        begin
                            if (idx_w >= cnt_w)
                            begin
                                fin        = 1'b1;
                                fin_status = cas_pkg::ST_INDEX;
                            end
                            else if (idx_inc < cnt_w)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_inc[AW-1:0];
                                ptr_next   = idx_inc[AW-1:0];
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        cas_pkg::OP_READ:
                        begin
                            if (idx_w >= cnt_w)
                            begin
                                fin        = 1'b1;
                                fin_status = cas_pkg::ST_INDEX;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_w[AW-1:0];
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            flat_start = 1'b1;
                            state_next = S_FLAT;
                        end
                    endcase
                end
            end
            S_FLAT:
            begin
                if (flat_rsp.done)
                begin
                    if (flat_rsp.coord_err)
                    begin
                        fin        = 1'b1;
                        fin_status = cas_pkg::ST_COORD;
                    end
                    else if (flat_rsp.flat >= cnt_w)
                    begin
                        fin        = 1'b1;
                        fin_status = cas_pkg::ST_INDEX;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = flat_rsp.flat[AW-1:0];
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                fin       = 1'b1;
                fin_value = mem_rdata;
            end
            S_SHIFT:
            begin
                // The element read last cycle moves down one place.
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (ptr_inc < cnt_w)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc[AW-1:0];
                    ptr_next  = ptr_inc[AW-1:0];
                end
                else
                begin
                    fin        = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? S_IDLE : S_DONE;
        end
    end

    // Output register and the holding slot for a result that must wait.
    always_comb
    begin
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (fin && out_free)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = fin_value;
            out_status_next = fin_status;
            out_count_next  = cas_pkg::count_t'(count_next);
        end
        else if (fin)
        begin
            pend_value_next  = fin_value;
            pend_status_next = fin_status;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = pend_value_reg;
            out_status_next = pend_status_reg;
            out_count_next  = cas_pkg::count_t'(count_reg);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.read_value    = out_value_reg;
    assign result.status        = out_status_reg;
    assign result.element_count = out_count_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    // Element memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[cas_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_in_use_reg <= cas_pkg::dimcnt_t'(1);
            for (int i = 0; i < cas_pkg::MAX_DIMS; i++)
            begin
                dim_size_reg[i] <= cas_pkg::dim_t'(1);
            end
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                cas_pkg::REG_DIMS_IN_USE: dims_in_use_reg <= pwdata[cas_pkg::DIMCNT_W-1:0];
                cas_pkg::REG_DIM_SIZE_0:  dim_size_reg[0] <= pwdata[cas_pkg::DIM_W-1:0];
                cas_pkg::REG_DIM_SIZE_1:  dim_size_reg[1] <= pwdata[cas_pkg::DIM_W-1:0];
                cas_pkg::REG_DIM_SIZE_2:  dim_size_reg[2] <= pwdata[cas_pkg::DIM_W-1:0];
                cas_pkg::REG_DIM_SIZE_3:  dim_size_reg[3] <= pwdata[cas_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            cas_pkg::REG_DIMS_IN_USE: prdata = cas_pkg::pdata_t'(dims_in_use_reg);
            cas_pkg::REG_DIM_SIZE_0:  prdata = cas_pkg::pdata_t'(dim_size_reg[0]);
            cas_pkg::REG_DIM_SIZE_1:  prdata = cas_pkg::pdata_t'(dim_size_reg[1]);
            cas_pkg::REG_DIM_SIZE_2:  prdata = cas_pkg::pdata_t'(dim_size_reg[2]);
            cas_pkg::REG_DIM_SIZE_3:  prdata = cas_pkg::pdata_t'(dim_size_reg[3]);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/cas_tb_pkg.sv =====
// Item and result types of the compacting array store bench, and its scoreboard class.
`timescale 1ns / 1ps

package cas_tb_pkg;
    import cas_pkg::*;

    localparam int STORE_DEPTH = 1024;

    // One item beat as the bench sends it.
    typedef struct {
        op_t        operation;
        value_t     value;
        idx_t       index;
        coord_vec_t coord;
    } store_op_t;

    // One result beat.
    typedef struct {
        value_t  read_value;
        status_t status;
        count_t  element_count;
    } store_answer_t;

    // Shadow copy of the store that works out the answer to every accepted item
    // and compares the result beats against those answers in order.
    class array_store_scoreboard;
        value_t        elements [STORE_DEPTH];
        int unsigned   count;
        dimcnt_t       dims;
        dim_t          extent [MAX_DIMS];
        store_answer_t pending_answers [$];
        int            errors;
        int            items_taken;

        function new();
            count       = 0;
            dims        = 1;
            errors      = 0;
            items_taken = 0;
            for (int i = 0; i < MAX_DIMS; i++)
                extent[i] = 1;
        endfunction

        // Mirror a register write.
        function void set_reg(reg_idx_t r, pdata_t d);
            case (r)
                REG_DIMS_IN_USE: dims      = dimcnt_t'(d);
                REG_DIM_SIZE_0:  extent[0] = dim_t'(d);
                REG_DIM_SIZE_1:  extent[1] = dim_t'(d);
                REG_DIM_SIZE_2:  extent[2] = dim_t'(d);
                REG_DIM_SIZE_3:  extent[3] = dim_t'(d);
                default: ;
            endcase
        endfunction

        // Apply an accepted item to the shadow store and queue its answer.
        function void note_item(store_op_t it);
            store_answer_t   ans;
            int unsigned     used;
            longint unsigned flat;
            bit              coord_bad;
            ans.read_value = '0;
            ans.status     = ST_OK;
            case (it.operation)
                OP_APPEND:
                begin
                    if (count >= STORE_DEPTH)
                        ans.status = ST_FULL;
                    else
                    begin
                        elements[count] = it.value;
                        count++;
                    end
                end
                OP_REMOVE:
                begin
                    if (it.index >= count)
                        ans.status = ST_INDEX;
                    else
                    begin
                        for (int unsigned i = it.index; i + 1 < count; i++)
                            elements[i] = elements[i + 1];
                        count--;
                    end
                end
                OP_READ:
                begin
                    if (it.index >= count)
                        ans.status = ST_INDEX;
                    else
                        ans.read_value = elements[it.index];
                end
                OP_COORD:
                begin
                    // Row-major flattening, outermost first, with no wrap.
                    used      = (dims > MAX_DIMS) ? MAX_DIMS : dims;
                    flat      = 0;
                    coord_bad = 1'b0;
                    for (int i = 0; i < used && !coord_bad; i++)
                    begin
                        if (it.coord[i] >= extent[i])
                            coord_bad = 1'b1;
                        else
                            flat = flat * extent[i] + it.coord[i];
                    end
                    if (coord_bad)
                        ans.status = ST_COORD;
                    else if (flat >= count)
                        ans.status = ST_INDEX;
                    else
                        ans.read_value = elements[flat];
                end
                default: ;
            endcase
            ans.element_count = count_t'(count);
            pending_answers.insert(pending_answers.size(), ans);
            items_taken++;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Compare a result beat with the oldest outstanding answer.
        task check_answer(store_answer_t got);
            store_answer_t want;
            if (pending_answers.size() == 0)
                report($sformatf("result beat with nothing outstanding (value %0d status %0d count %0d)",
                                 got.read_value, got.status, got.element_count));
            else
            begin
                want = pending_answers.pop_front();
                if (got.read_value !== want.read_value)
                    report($sformatf("read_value %0d, expected %0d",
                                     got.read_value, want.read_value));
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.element_count !== want.element_count)
                    report($sformatf("element_count %0d, expected %0d",
                                     got.element_count, want.element_count));
            end
        endtask
    endclass

endpackage

// ===== tb/sv/tb_compacting_array_store_top.sv =====
// Bench top of the compacting array store: clock, reset, item and result drivers, watchdog.
`timescale 1ns / 1ps

module tb_compacting_array_store_top;
    import cas_pkg::*;
    import cas_tb_pkg::*;

    localparam int NUM_PHASES     = 13;
    localparam int FILL_PHASE     = 2;
    localparam int PHASE_ITEMS    = 36;
    localparam int PRESSURE_AT    = 400;
    localparam int PRESSURE_HOLD  = 300;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 24;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    pdata_t             pwdata;
    pdata_t             prdata;
    logic               pready;

    cas_in_if  item_ch ();
    cas_out_if result_ch ();

    array_store_scoreboard store_chk;
    bit                    quiet_gaps = 1'b0;
    int                    stall_cycles = 0;

    // Register settings per phase: dimension count, then extents outermost first.
    int phase_dims [NUM_PHASES] = '{1, 2, 4, 3, 4, 0, 7, 5, 2, 4, 1, 6, 1};
    int phase_ext  [NUM_PHASES][MAX_DIMS] = '{
        '{1024, 1, 1, 1},
        '{32, 32, 1, 1},
        '{4, 4, 8, 8},
        '{16, 8, 8, 1},
        '{1024, 1024, 1024, 1024},
        '{5, 5, 5, 5},
        '{2, 4, 8, 16},
        '{1, 1, 1, 1024},
        '{0, 5, 3, 3},
        '{2047, 2047, 2047, 2047},
        '{2047, 1, 1, 1},
        '{8, 8, 4, 4},
        '{1, 1, 1, 1}
    };

    compacting_array_store_top #(
        .DEPTH (STORE_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Gap length for either side: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item beat after a random gap and hold it until it is taken.
    task automatic send_item(store_op_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= it.operation;
        item_ch.value     <= it.value;
        item_ch.index     <= it.index;
        item_ch.coord_0   <= it.coord[0];
        item_ch.coord_1   <= it.coord[1];
        item_ch.coord_2   <= it.coord[2];
        item_ch.coord_3   <= it.coord[3];
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        store_chk.note_item(it);
    endtask

    task automatic send_op(op_t op, value_t v, idx_t idx,
                           coord_t c0, coord_t c1, coord_t c2, coord_t c3);
        store_op_t it;
        it.operation = op;
        it.value     = v;
        it.index     = idx;
        it.coord[0]  = c0;
        it.coord[1]  = c1;
        it.coord[2]  = c2;
        it.coord[3]  = c3;
        send_item(it);
    endtask

    // Random item shaped by the current fill level and extents.
    function automatic store_op_t random_item(int append_pct, int remove_pct);
        store_op_t   it;
        int          r;
        int unsigned n;
        int unsigned span;
        int unsigned lim;
        n = store_chk.count;
        r = $urandom_range(0, 99);
        if (r < append_pct)
            it.operation = OP_APPEND;
        else if (r < append_pct + remove_pct)
            it.operation = OP_REMOVE;
        else if ($urandom_range(0, 1) == 0)
            it.operation = OP_READ;
        else
            it.operation = OP_COORD;

        case ($urandom_range(0, 19))
            0:       it.value = 32'h8000_0000;
            1:       it.value = 32'h7FFF_FFFF;
            2:       it.value = 32'h0000_0000;
            3:       it.value = 32'hFFFF_FFFF;
            default: it.value = $urandom;
        endcase

        // Removes mostly near the tail to keep the shifts short.
        r = $urandom_range(0, 9);
        if (n == 0 || r == 0)
            it.index = idx_t'($urandom);
        else if (it.operation == OP_REMOVE && r < 8)
        begin
            span     = (n - 1 < 15) ? n - 1 : 15;
            it.index = idx_t'(n - 1 - $urandom_range(0, span));
        end
        else if (r == 9)
            it.index = idx_t'(n - 1);
        else
            it.index = idx_t'($urandom_range(0, n - 1));

        // Coordinates mostly inside their extents, some at the edge or anywhere.
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            lim = (store_chk.extent[i] > 1024) ? 1024 : store_chk.extent[i];
            r   = $urandom_range(0, 9);
            if (r < 2)
                it.coord[i] = '0;
            else if (r < 8 && lim > 0)
                it.coord[i] = coord_t'($urandom_range(0, lim - 1));
            else if (r == 8 && lim > 0)
                it.coord[i] = coord_t'(lim - 1);
            else
                it.coord[i] = coord_t'($urandom);
        end
        return it;
    endfunction

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (store_chk.pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; psel stays up across back-to-back writes.
    task automatic apb_write(reg_idx_t r, pdata_t d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        store_chk.set_reg(r, d);
    endtask

    task automatic load_phase(int ph);
        wait_drained();
        apb_write(REG_DIMS_IN_USE, pdata_t'(phase_dims[ph]));
        apb_write(REG_DIM_SIZE_0, pdata_t'(phase_ext[ph][0]));
        apb_write(REG_DIM_SIZE_1, pdata_t'(phase_ext[ph][1]));
        apb_write(REG_DIM_SIZE_2, pdata_t'(phase_ext[ph][2]));
        apb_write(REG_DIM_SIZE_3, pdata_t'(phase_ext[ph][3]));
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        quiet_gaps = (ph % 4 == 1);
    endtask

    // Fill the store to capacity, push against the full store, then shift it all.
    task automatic fill_store();
        while (store_chk.count < STORE_DEPTH)
            send_item(random_item(80, 0));
        repeat (8) send_item(random_item(100, 0));
        send_op(OP_READ, '0, 10'd1023, '0, '0, '0, '0);
        send_op(OP_COORD, '0, '0, 10'd3, 10'd3, 10'd7, 10'd7);
        send_op(OP_REMOVE, '0, '0, '0, '0, '0, '0);
        send_op(OP_REMOVE, '0, '0, '0, '0, '0, '0);
        repeat (4) send_item(random_item(100, 0));
    endtask

    // Main stimulus.
    initial
    begin : stimulus
        store_chk = new();
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.operation <= OP_APPEND;
        item_ch.value     <= '0;
        item_ch.index     <= '0;
        item_ch.coord_0   <= '0;
        item_ch.coord_1   <= '0;
        item_ch.coord_2   <= '0;
        item_ch.coord_3   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: reads, removes and coordinate reads all miss.
        send_op(OP_READ, '0, '0, '0, '0, '0, '0);
        send_op(OP_REMOVE, '0, '0, '0, '0, '0, '0);
        send_op(OP_COORD, '0, '0, '0, 10'd1023, 10'd1023, 10'd1023);
        send_op(OP_COORD, '0, '0, 10'd1, '0, '0, '0);

        // Value extremes and alternating patterns.
        send_op(OP_APPEND, 32'h8000_0000, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_op(OP_APPEND, 32'h7FFF_FFFF, '0, '0, '0, '0, '0);
        send_op(OP_APPEND, 32'h0000_0000, '0, '0, '0, '0, '0);
        send_op(OP_APPEND, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
        send_op(OP_APPEND, 32'h5555_5555, '0, '0, '0, '0, '0);
        send_op(OP_APPEND, 32'hAAAA_AAAA, '0, '0, '0, '0, '0);

        // Reads at the ends and just past the count.
        send_op(OP_READ, '0, '0, '0, '0, '0, '0);
        send_op(OP_READ, '0, 10'd5, '0, '0, '0, '0);
        send_op(OP_READ, '0, 10'd6, '0, '0, '0, '0);
        send_op(OP_READ, '0, 10'd1023, '0, '0, '0, '0);
        send_op(OP_COORD, '0, '0, '0, 10'd1023, 10'd1023, 10'd1023);

        // Remove the last, the first and a middle element, then read back.
        send_op(OP_REMOVE, '0, 10'd5, '0, '0, '0, '0);
        send_op(OP_REMOVE, '0, '0, '0, '0, '0, '0);
        send_op(OP_REMOVE, '0, 10'd1, '0, '0, '0, '0);
        send_op(OP_READ, '0, '0, '0, '0, '0, '0);
        send_op(OP_READ, '0, 10'd1, '0, '0, '0, '0);
        send_op(OP_READ, '0, 10'd2, '0, '0, '0, '0);
        send_op(OP_READ, '0, 10'd3, '0, '0, '0, '0);
        send_op(OP_REMOVE, '0, 10'd1023, '0, '0, '0, '0);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            load_phase(ph);
            if (ph == FILL_PHASE)
                fill_store();
            else
                repeat (PHASE_ITEMS) send_item(random_item(35, 25));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (store_chk.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: random stalls after each beat, and one long hold-off so the
    // block backs up into its item channel.
    initial
    begin : result_sink
        int            stall_left;
        bit            pressure_done;
        store_answer_t got;
        stall_left    = 0;
        pressure_done = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.read_value    = result_ch.read_value;
                got.status        = result_ch.status;
                got.element_count = result_ch.element_count;
                store_chk.check_answer(got);
                stall_left = pick_gap();
            end
            if (!pressure_done && store_chk.items_taken >= PRESSURE_AT)
            begin
                stall_left    = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // End the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin : watchdog
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
